// ----- rtl/jfss_pkg.sv -----
// jfss_pkg: shared types, marker codes and helpers for the jpeg frame size scanner
// no dependencies; imported by every module of the block except jfss_checker
`default_nettype none

package jfss_pkg;

   // marker bytes
   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI    = 8'hD8;
   localparam logic [7:0] MARK_EOI    = 8'hD9;
   localparam logic [7:0] SOF_FIRST   = 8'hC0;
   localparam logic [7:0] SOF_LAST    = 8'hCF;
   localparam logic [7:0] MARK_DHT    = 8'hC4;
   localparam logic [7:0] MARK_JPG    = 8'hC8;
   localparam logic [7:0] MARK_DAC    = 8'hCC;

   // length limits
   localparam int unsigned MIN_IMAGE_LENGTH = 10;
   localparam int unsigned SCAN_LOOKAHEAD   = 8;
   localparam int unsigned SCAN_START       = 2;
   localparam int unsigned MIN_SEGMENT      = 2;
   localparam int unsigned MIN_SOF_SEGMENT  = 7;

   localparam int unsigned IMAGE_LENGTH_W = 24;
   localparam int unsigned DIM_W          = 16;

   // parse phase
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SOI,
      PH_SEEK,
      PH_MARKER,
      PH_LENHI,
      PH_LENLO,
      PH_PREC,
      PH_HHI,
      PH_HLO,
      PH_WHI,
      PH_WLO
   } phase_type;

   // one input word
   typedef struct packed {
      logic [IMAGE_LENGTH_W-1:0] image_length;
      logic                      image_start;
      logic [7:0]                data_byte;
   } item_type;

   // one result word
   typedef struct packed {
      logic             found;
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
   } result_type;

   // start-of-frame markers: C0..CF except DHT, JPG and DAC
   function automatic logic is_sof_marker(input logic [7:0] code);
      is_sof_marker = (code >= SOF_FIRST) && (code <= SOF_LAST) &&
                      (code != MARK_DHT) && (code != MARK_JPG) && (code != MARK_DAC);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/jfss_in_reg.sv -----
// jfss_in_reg: input register of the scanner, holds one accepted word
// depends on jfss_pkg for the word type
`default_nettype none

module jfss_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire jfss_pkg::item_type in_item,
   output logic                   item_valid,
   output jfss_pkg::item_type     item,
   input  wire logic              item_take
);
   import jfss_pkg::*;

   logic     valid_ff;
   item_type item_ff;

   // free when empty or when the held word is consumed this cycle
   assign in_ready   = !valid_ff || item_take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/jfss_step.sv -----
// jfss_step: parse state and the per-byte marker scan logic of the scanner
// depends on jfss_pkg for phase codes, marker constants and word types
`default_nettype none

module jfss_step #(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire jfss_pkg::item_type item,
   output logic                    item_take,
   input  wire logic               out_space,
   output logic                    emit,
   output jfss_pkg::result_type    result
);
   import jfss_pkg::*;

   // offsets get two spare bits so offset + segment + lookahead never wraps
   localparam int unsigned CNT_W   = LENGTH_BITS + 2;
   localparam int unsigned LEN_USE =
      (LENGTH_BITS < IMAGE_LENGTH_W) ? LENGTH_BITS : IMAGE_LENGTH_W;

   phase_type           phase_ff, phase_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    offset_ff, offset_in;
   logic [7:0]          marker_ff, marker_in;
   logic [7:0]          seg_hi_ff, seg_hi_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [7:0]          width_hi_ff, width_hi_in;

   logic [7:0]          b;
   logic                start;
   logic [CNT_W-1:0]    len;
   logic [DIM_W-1:0]    seg_full;
   logic [CNT_W-1:0]    off_adv;
   logic                adv_end;
   logic                seg_bad;
   logic                sof_go;
   logic                at_offset;
   logic                start_bad;
   logic [DIM_W-1:0]    width_full;

   assign b          = item.data_byte;
   assign start      = item.image_start;
   assign len        = {{(CNT_W-LEN_USE){1'b0}}, item.image_length[LEN_USE-1:0]};
   assign seg_full   = {seg_hi_ff, b};
   assign width_full = {width_hi_ff, b};
   assign at_offset  = (pos_ff == offset_ff);
   assign start_bad  = (len < CNT_W'(MIN_IMAGE_LENGTH)) || (b != MARK_PREFIX);

   // candidate next offset for the current phase
   always_comb begin
      case (phase_ff)
         PH_SOI:    off_adv = CNT_W'(SCAN_START);
         PH_SEEK:   off_adv = offset_ff + CNT_W'(1);
         PH_MARKER: off_adv = offset_ff + CNT_W'(2);
         PH_LENLO:  off_adv = offset_ff + CNT_W'(2) + {{(CNT_W-DIM_W){1'b0}}, seg_full};
         default:   off_adv = offset_ff;
      endcase
   end

   // scan end and segment checks
   assign adv_end = (off_adv + CNT_W'(SCAN_LOOKAHEAD)) >= len;
   assign seg_bad = (seg_full < DIM_W'(MIN_SEGMENT)) || (off_adv > len);
   assign sof_go  = is_sof_marker(marker_ff) && (seg_full >= DIM_W'(MIN_SOF_SEGMENT));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         phase_in = start_bad ? PH_IDLE : PH_SOI;
      end else begin
         unique case (phase_ff)
            PH_IDLE: phase_in = PH_IDLE;
            PH_SOI: begin
               if (b != MARK_SOI || adv_end) phase_in = PH_IDLE;
               else                          phase_in = PH_SEEK;
            end
            PH_SEEK: begin
               if (at_offset) begin
                  if (b == MARK_PREFIX) phase_in = PH_MARKER;
                  else if (adv_end)     phase_in = PH_IDLE;
                  else                  phase_in = PH_SEEK;
               end
            end
            PH_MARKER: begin
               if (b == MARK_SOI || b == MARK_EOI) phase_in = adv_end ? PH_IDLE : PH_SEEK;
               else                                phase_in = PH_LENHI;
            end
            PH_LENHI: phase_in = PH_LENLO;
            PH_LENLO: begin
               if (seg_bad)      phase_in = PH_IDLE;
               else if (sof_go)  phase_in = PH_PREC;
               else if (adv_end) phase_in = PH_IDLE;
               else              phase_in = PH_SEEK;
            end
            PH_PREC: phase_in = PH_HHI;
            PH_HHI:  phase_in = PH_HLO;
            PH_HLO:  phase_in = PH_WHI;
            PH_WHI:  phase_in = PH_WLO;
            PH_WLO:  phase_in = PH_IDLE;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // result: every drop into idle from an open image, or a failed start, decides
   always_comb begin
      emit                = (phase_in == PH_IDLE) && (start || (phase_ff != PH_IDLE));
      result.found        = 1'b0;
      result.frame_width  = '0;
      result.frame_height = '0;
      if (!start && phase_ff == PH_WLO) begin
         result.found        = (width_full != '0) && (height_ff != '0);
         result.frame_width  = width_full;
         result.frame_height = height_ff;
      end
   end

   // position, offset and captured fields
   always_comb begin
      pos_in      = pos_ff;
      offset_in   = offset_ff;
      marker_in   = marker_ff;
      seg_hi_in   = seg_hi_ff;
      height_in   = height_ff;
      width_hi_in = width_hi_ff;
      if (start) begin
         pos_in      = CNT_W'(1);
         offset_in   = CNT_W'(SCAN_START);
         marker_in   = '0;
         seg_hi_in   = '0;
         height_in   = '0;
         width_hi_in = '0;
      end else if (phase_ff != PH_IDLE) begin
         pos_in = pos_ff + CNT_W'(1);
         case (phase_ff)
            PH_SOI: offset_in = off_adv;
            PH_SEEK: begin
               if (at_offset && b != MARK_PREFIX) offset_in = off_adv;
            end
            PH_MARKER: begin
               marker_in = b;
               if (b == MARK_SOI || b == MARK_EOI) offset_in = off_adv;
            end
            PH_LENHI: seg_hi_in = b;
            PH_LENLO: begin
               if (!seg_bad && !sof_go) offset_in = off_adv;
            end
            PH_HHI:  height_in   = {b, 8'h00};
            PH_HLO:  height_in   = {height_ff[15:8], b};
            PH_WHI:  width_hi_in = b;
            default: ;
         endcase
      end
   end

   // a word is consumed unless it decides and the result register is full
   assign item_take = item_valid && (!emit || out_space);

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (item_take) begin
         phase_ff <= phase_in;
      end
   end

   // scan registers, only meaningful after an image start
   always_ff @(posedge clock) begin
      if (item_take) begin
         pos_ff      <= pos_in;
         offset_ff   <= offset_in;
         marker_ff   <= marker_in;
         seg_hi_ff   <= seg_hi_in;
         height_ff   <= height_in;
         width_hi_ff <= width_hi_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/jfss_out_reg.sv -----
// jfss_out_reg: result register of the scanner, holds one word for the receiver
// depends on jfss_pkg for the result type
`default_nettype none

module jfss_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire jfss_pkg::result_type load_result,
   output logic                      space,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output jfss_pkg::result_type      out_result
);
   import jfss_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // room when empty or draining this cycle
   assign space      = !valid_ff || out_ready;
   assign valid_in   = (load && space) || (valid_ff && !out_ready);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load && space) begin
         result_ff <= load_result;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/jpeg_frame_size_scanner.sv -----
// jpeg_frame_size_scanner: top level, input register, scan logic, result register
// depends on jfss_pkg, jfss_in_reg, jfss_step and jfss_out_reg
//
// Usage
//   req channel: one image byte per word. req_tuser marks byte 0 of a new image;
//   req_tdata carries the byte and the total image length, the length being
//   repeated on every byte. The block finds the start-of-frame header and gives
//   at most one rsp word per image: found in rsp_tuser, width and height in
//   rsp_tdata (both zero on a failure before a frame header was read).
//   Bytes after the deciding one are ignored until the next image start; a new
//   start in mid image drops the open image without a result.
//   Throughput: one byte per cycle, set by the single scan step between the
//   input register and the result register.
//   Output: the result of a deciding byte is registered in the result register.
//   Stall: while the result register is full and not taken, bytes that do not
//   decide still flow; a deciding byte waits in the input register, which then
//   holds req_tready low.
//   Reset: synchronous; clears both registers and returns the scan to idle, so
//   bytes before the first image start give nothing.
`default_nettype none

module jpeg_frame_size_scanner #(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [7:0] data_byte, [31:8] image_length
   input  wire logic        req_tuser,   // [0] image_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] frame_width, [31:16] frame_height
   output logic             rsp_tuser    // [0] found
);
   import jfss_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       item_take;
   logic       out_space;
   logic       emit;
   result_type result;
   result_type rsp_result;

   // unpack the request word
   assign req_item.data_byte    = req_tdata[7:0];
   assign req_item.image_length = req_tdata[31:8];
   assign req_item.image_start  = req_tuser;

   jfss_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   jfss_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_space  (out_space),
      .emit       (emit),
      .result     (result)
   );

   jfss_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (item_take && emit),
      .load_result (result),
      .space       (out_space),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (rsp_result)
   );

   // pack the response word
   assign rsp_tdata = {rsp_result.frame_height, rsp_result.frame_width};
   assign rsp_tuser = rsp_result.found;

endmodule

`default_nettype wire

// ----- rtl/jfss_checker.sv -----
// jfss_checker: port-level assertions for the jpeg frame size scanner
// binds to jpeg_frame_size_scanner; no package dependency
`default_nettype none

module jfss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // found means both dimensions are nonzero
   a_found_dims: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] != 16'h0 && rsp_tdata[31:16] != 16'h0)
      else $error("found with a zero dimension");

   // with the result register empty the input side never stalls
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

endmodule

bind jpeg_frame_size_scanner jfss_checker u_jfss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: streams jpeg-like images through jpeg_frame_size_scanner and checks every result word
// depends on jfss_pkg and the jpeg_frame_size_scanner rtl; built-in predictor, no external files
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import jfss_pkg::*;

   // marker codes used by directed images that the package does not name
   localparam logic [7:0] MARK_SOF_PROG = 8'hC2;
   localparam logic [7:0] MARK_APP0     = 8'hE0;

   localparam int unsigned RANDOM_BYTES = 1700;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned QUIET_LIMIT  = 5000;

   // predictor of the scan and store of expected size words
   class dimension_board;
      phase_type       phase;
      longint unsigned position;
      longint unsigned next_offset;
      logic [7:0]      marker;
      longint unsigned seg_length;
      logic [15:0]     height;
      logic [15:0]     width;
      bit              settled;
      result_type      expected_sizes[$];
      int unsigned     errors;
      int unsigned     images;
      int unsigned     checked;

      function new();
         phase       = PH_IDLE;
         position    = 0;
         next_offset = SCAN_START;
         marker      = '0;
         seg_length  = 0;
         height      = '0;
         width       = '0;
         settled     = 1'b1;
         errors      = 0;
         images      = 0;
         checked     = 0;
      endfunction

      // start-of-frame codes: C0..CF less the table and reserved codes
      static function bit frame_marker(logic [7:0] code);
         return (code >= SOF_FIRST) && (code <= SOF_LAST) && (code != MARK_DHT) &&
                (code != MARK_JPG) && (code != MARK_DAC);
      endfunction

      function void settle(bit ok);
         result_type r;
         r.found        = ok;
         r.frame_width  = width;
         r.frame_height = height;
         expected_sizes.push_back(r);
         settled = 1'b1;
         phase   = PH_IDLE;
      endfunction

      // go on seeking while the lookahead still fits in the image
      function void keep_seeking(longint unsigned len);
         if (next_offset + SCAN_LOOKAHEAD >= len) settle(1'b0);
         else phase = PH_SEEK;
      endfunction

      function void take_byte(logic [7:0] b, bit start, logic [23:0] len_in);
         longint unsigned len;
         len = len_in;
         // image start resets the scan
         if (start) begin
            position    = 0;
            next_offset = SCAN_START;
            marker      = '0;
            seg_length  = 0;
            height      = '0;
            width       = '0;
            settled     = 1'b0;
            images++;
            if (len < MIN_IMAGE_LENGTH || b != MARK_PREFIX) begin
               settle(1'b0);
            end else begin
               phase    = PH_SOI;
               position = 1;
            end
            return;
         end
         if (settled || phase == PH_IDLE) return;
         case (phase)
            PH_SOI: begin
               if (b != MARK_SOI) begin
                  settle(1'b0);
               end else begin
                  next_offset = SCAN_START;
                  keep_seeking(len);
               end
            end
            PH_SEEK: begin
               if (position == next_offset) begin
                  if (b != MARK_PREFIX) begin
                     next_offset++;
                     keep_seeking(len);
                  end else begin
                     phase = PH_MARKER;
                  end
               end
            end
            PH_MARKER: begin
               marker = b;
               if (b == MARK_SOI || b == MARK_EOI) begin
                  next_offset += 2;
                  keep_seeking(len);
               end else begin
                  phase = PH_LENHI;
               end
            end
            PH_LENHI: begin
               seg_length = {b, 8'h00};
               phase      = PH_LENLO;
            end
            PH_LENLO: begin
               seg_length = seg_length | b;
               if (seg_length < MIN_SEGMENT || next_offset + 2 + seg_length > len) begin
                  settle(1'b0);
               end else if (frame_marker(marker) && seg_length >= MIN_SOF_SEGMENT) begin
                  phase = PH_PREC;
               end else begin
                  next_offset += 2 + seg_length;
                  keep_seeking(len);
               end
            end
            PH_PREC: phase = PH_HHI;
            PH_HHI: begin
               height = {b, 8'h00};
               phase  = PH_HLO;
            end
            PH_HLO: begin
               height[7:0] = b;
               phase       = PH_WHI;
            end
            PH_WHI: begin
               width = {b, 8'h00};
               phase = PH_WLO;
            end
            PH_WLO: begin
               width[7:0] = b;
               settle(width != 0 && height != 0);
            end
            default: ;
         endcase
         if (!settled) position++;
      endfunction

      function void check_result(logic found, logic [15:0] w, logic [15:0] h);
         result_type e;
         if (expected_sizes.size() == 0) begin
            $error("unexpected result word: found %0d, width %0d, height %0d", found, w, h);
            errors++;
            return;
         end
         e = expected_sizes.pop_front();
         checked++;
         if (found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, found);
            errors++;
         end
         if (w !== e.frame_width) begin
            $error("frame_width: expected %0d, got %0d", e.frame_width, w);
            errors++;
         end
         if (h !== e.frame_height) begin
            $error("frame_height: expected %0d, got %0d", e.frame_height, h);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_sizes.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // [7:0] data_byte, [31:8] image_length
   logic        req_tuser  = 1'b0;  // [0] image_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [15:0] frame_width, [31:16] frame_height
   logic        rsp_tuser;          // [0] found

   dimension_board board = new();
   logic [7:0]     image_bytes[$];
   int unsigned    image_bytes_sent = 0;
   bit             tx_calm = 1'b0;
   int unsigned    quiet_cycles = 0;

   jpeg_frame_size_scanner u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // idle length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one byte word, waits for the handshake and feeds the predictor
   task automatic send_byte(input logic [7:0] b, input bit start, input logic [23:0] len);
      int unsigned gap;
      gap = tx_calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= $urandom_range(0, 1);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, b};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      board.take_byte(b, start, len);
   endtask

   task automatic send_image(input logic [23:0] len);
      foreach (image_bytes[i]) send_byte(image_bytes[i], i == 0, len);
      image_bytes_sent += image_bytes.size();
   endtask

   // well-formed image: start marker, random filler, standalone markers and segments, then a frame header
   function automatic void build_frame_image();
      int unsigned seg;
      logic [7:0]  code;
      logic [15:0] h;
      logic [15:0] w;
      image_bytes = '{MARK_PREFIX, MARK_SOI};
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 4)) image_bytes.push_back(8'($urandom_range(0, 8'hFE)));
            1: begin
               image_bytes.push_back(MARK_PREFIX);
               image_bytes.push_back($urandom_range(0, 1) ? MARK_SOI : MARK_EOI);
            end
            default: begin
               code = 8'($urandom_range(0, 255));
               if (code == MARK_SOI || code == MARK_EOI) code = MARK_DHT;
               seg = $urandom_range(MIN_SEGMENT, 12);
               // a frame code with a short segment is skipped like any other
               if (dimension_board::frame_marker(code) && seg >= MIN_SOF_SEGMENT)
                  seg = $urandom_range(MIN_SEGMENT, MIN_SOF_SEGMENT - 1);
               image_bytes.push_back(MARK_PREFIX);
               image_bytes.push_back(code);
               image_bytes.push_back(8'(seg >> 8));
               image_bytes.push_back(8'(seg));
               repeat (seg - 2) image_bytes.push_back(8'($urandom));
            end
         endcase
      end
      do code = 8'($urandom_range(SOF_FIRST, SOF_LAST)); while (!dimension_board::frame_marker(code));
      seg = $urandom_range(MIN_SOF_SEGMENT, 17);
      h = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom_range(1, 16'hFFFF));
      w = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom_range(1, 16'hFFFF));
      image_bytes.push_back(MARK_PREFIX);
      image_bytes.push_back(code);
      image_bytes.push_back(8'(seg >> 8));
      image_bytes.push_back(8'(seg));
      image_bytes.push_back(8'($urandom));
      image_bytes.push_back(h[15:8]);
      image_bytes.push_back(h[7:0]);
      image_bytes.push_back(w[15:8]);
      image_bytes.push_back(w[7:0]);
      repeat (seg - MIN_SOF_SEGMENT) image_bytes.push_back(8'($urandom));
   endfunction

   // result side: random stalls, calm stretches and one long hold
   initial begin : rsp_side
      int unsigned stall_left;
      bit          held;
      bit          calm;
      stall_left = 0;
      held       = 1'b0;
      calm       = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
         if (!held && image_bytes_sent >= 400) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 63) == 0) calm = !calm;
            if (!calm) stall_left = pick_gap();
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** jpeg_frame_size_scanner: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned kind;
      int unsigned k;
      int unsigned total;
      logic [23:0] len;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // bytes before any image start are ignored
      send_byte(MARK_PREFIX, 1'b0, 24'd20);
      send_byte(MARK_SOI, 1'b0, 24'd20);
      // image length below the minimum fails on byte 0
      image_bytes = '{MARK_PREFIX, MARK_SOI};
      send_image(24'd9);
      // length at the minimum runs out of scan room on byte 1
      send_image(24'd10);
      // byte 0 not a marker prefix
      image_bytes = '{8'h00, MARK_SOI};
      send_image(24'hFFFFFF);
      // byte 1 not the image start code
      image_bytes = '{MARK_PREFIX, 8'h00};
      send_image(24'd100);
      // new start in mid image drops the open one
      image_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX};
      send_image(24'd50);
      // smallest image with a frame header
      image_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, SOF_FIRST, 8'h00, 8'h07,
                      8'h08, 8'h00, 8'h01, 8'h00, 8'h01};
      send_image(24'd11);
      // standalone markers, filler, a table, a short frame code, then largest sizes
      image_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_EOI, MARK_PREFIX, MARK_SOI,
                      8'h55, MARK_PREFIX, MARK_DHT, 8'h00, 8'h02,
                      MARK_PREFIX, MARK_SOF_PROG, 8'h00, 8'h06, 8'h01, 8'h02, 8'h03, 8'h04,
                      MARK_PREFIX, SOF_LAST, 8'h00, 8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hAA};
      send_image(24'hFFFFFF);
      // zero height reports both values with found low
      image_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, SOF_FIRST, 8'h00, 8'h07,
                      8'h08, 8'h00, 8'h00, 8'h12, 8'h34};
      send_image(24'd11);
      // segment length under two
      image_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP0, 8'h00, 8'h01};
      send_image(24'd40);
      // segment running past the image end
      image_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP0, 8'h80, 8'h00};
      send_image(24'd40);
      // scan runs out on filler bytes, the rest is ignored
      image_bytes = '{MARK_PREFIX, MARK_SOI, 8'h00, 8'h11, 8'h22, 8'h33};
      send_image(24'd12);

      // random images: mostly well formed, some damaged, cut short or noise
      while (image_bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
         kind = $urandom_range(0, 99);
         build_frame_image();
         total = image_bytes.size();
         if ($urandom_range(0, 3) == 0) len = 24'($urandom_range(total, 24'hFFFFFF));
         else len = 24'(total + $urandom_range(0, 6));
         if (kind < 70) begin
         end else if (kind < 80) begin
            image_bytes[$urandom_range(0, total - 1)] = 8'($urandom);
         end else if (kind < 88) begin
            k = $urandom_range(1, total - 1);
            while (image_bytes.size() > k) void'(image_bytes.pop_back());
         end else if (kind < 94) begin
            len = 24'($urandom_range(0, 15));
         end else begin
            image_bytes.delete();
            repeat ($urandom_range(1, 24)) image_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 1)) image_bytes[0] = MARK_PREFIX;
            if (image_bytes.size() > 1 && $urandom_range(0, 1)) image_bytes[1] = MARK_SOI;
            len = 24'($urandom_range(0, 40));
         end
         send_image(len);
         // stray bytes after the image
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, len);
      end
      req_tvalid <= 1'b0;

      // drain, then allow for the result latency
      while (board.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("%0d image bytes over %0d images, %0d size words checked", image_bytes_sent,
               board.images, board.checked);
      $display("covered bad headers, bad segments, scan exhaustion, dropped images, result hold");
      if (board.errors == 0) begin
         $display("** jpeg_frame_size_scanner: PASSED **");
      end else begin
         $display("** jpeg_frame_size_scanner: FAILED **");
      end
      $finish;
   end

endmodule
